/* src/mrrc_pkg.sv */
// Shared types and constants for the Modbus RTU response checker.
`default_nettype none

package mrrc_pkg;

   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_SEED = 16'hFFFF;
   localparam logic [7:0]  MIN_LEN  = 8'd5;
   localparam logic [15:0] LOW_MASK = 16'h00FF;
   localparam int          CRC_BITS = 8;

   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_STATION_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FUNCTION_CODE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LENGTH    = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_HEADER_BAD = 2'd1,
      STATUS_CRC_BAD    = 2'd2
   } status_type;

endpackage

`default_nettype wire

/* src/mrrc_crc16_byte.sv */
// CRC-16/MODBUS update over one byte, reflected, LSB first.
`default_nettype none

module mrrc_crc16_byte (
   input  wire logic [15:0] crc_in,
   input  wire logic [7:0]  data_in,
   output logic      [15:0] crc_out
);

   always_comb begin
      logic [15:0] c;
      c = crc_in ^ {8'h00, data_in};
      for (int k = 0; k < mrrc_pkg::CRC_BITS; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ mrrc_pkg::CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_out = c;
   end

endmodule

`default_nettype wire

/* src/modbus_rtu_response_checker_top.sv */
// Modbus RTU response checker: per-byte header and CRC-16 check with one status per frame.
//
// Usage:
//  req_* carries received bytes: tdata = rx_byte, tuser = frame_start (restarts the check).
//  csr_* writes station address (0), function code (1) and frame length (2); write only
//  while idle. Lengths below five count as five.
//  rsp_* carries one result per complete frame, on its final byte: status 0 ok,
//  1 header mismatch (wins over CRC), 2 CRC mismatch, plus the CRC over all but the
//  last two bytes. Bytes after a frame ends without frame_start are dropped.
//  Latency: a result is valid the cycle after its final byte is accepted.
//  Throughput: one byte per cycle while no result is stalled; the whole byte CRC update sits
//  between the CRC state register and itself (the result register takes the stored CRC).
//  Stall: the result register holds while rsp_tready is low and req_tready then drops,
//  so no request is taken until the waiting result is taken (tready passes straight
//  through to req_tready).
//  Reset (synchronous, active high): registers return to 1/3/7, byte position 0,
//  CRC seed 0xFFFF, no result pending.
`default_nettype none

module modbus_rtu_response_checker_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [mrrc_pkg::REQ_DATA_W-1:0] req_tdata,  // [7:0] rx_byte
   input  wire logic [mrrc_pkg::REQ_USER_W-1:0] req_tuser,  // [0] frame_start
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [mrrc_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [1:0] check_status,
                                                            // [17:2] computed_crc, [23:18] 0
   input  wire logic                            csr_we,
   input  wire logic [mrrc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mrrc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic [7:0]  station_ff, function_ff, length_ff;
   logic [7:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic        hdr_bad_ff, hdr_bad_in;
   logic        low_bad_ff, low_bad_in;
   logic        rsp_valid_ff, rsp_valid_in;
   mrrc_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_crc_ff, rsp_crc_in;

   logic        req_accept;
   logic [7:0]  rx;
   logic        start;
   logic [7:0]  len, len_m2, p;
   logic [15:0] crc_cur, crc_upd;
   logic        hdr_cur, low_cur;
   logic        ignore;

   assign rx         = req_tdata[7:0];
   assign start      = req_tuser[0];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign len     = (length_ff < mrrc_pkg::MIN_LEN) ? mrrc_pkg::MIN_LEN : length_ff;
   assign len_m2  = len - 8'd2;
   assign p       = start ? 8'd0 : pos_ff;
   assign crc_cur = start ? mrrc_pkg::CRC_SEED : crc_ff;
   assign hdr_cur = start ? 1'b0 : hdr_bad_ff;
   assign low_cur = start ? 1'b0 : low_bad_ff;
   assign ignore  = !start && (pos_ff >= len);

   mrrc_crc16_byte u_crc (
      .crc_in  (crc_cur),
      .data_in (rx),
      .crc_out (crc_upd)
   );

   always_comb begin
      logic [15:0] low_byte;
      logic        crc_bad;
      low_byte      = crc_cur & mrrc_pkg::LOW_MASK;
      crc_bad       = 1'b0;
      pos_in        = pos_ff;
      crc_in        = crc_ff;
      hdr_bad_in    = hdr_bad_ff;
      low_bad_in    = low_bad_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_crc_in    = rsp_crc_ff;
      if (req_accept && !ignore) begin
         pos_in     = p + 8'd1;
         crc_in     = crc_cur;
         low_bad_in = low_cur;
         hdr_bad_in = hdr_cur
                    || ((p == 8'd0) && (rx != station_ff))
                    || ((p == 8'd1) && (rx != function_ff))
                    || ((p == 8'd2) && (rx != (len - mrrc_pkg::MIN_LEN)));
         if (p < len_m2) begin
            crc_in = crc_upd;
         end else if (p == len_m2) begin
            low_bad_in = (rx != low_byte[7:0]);
         end else begin
            crc_bad      = low_cur || (rx != crc_cur[15:8]);
            rsp_valid_in = 1'b1;
            rsp_crc_in   = crc_cur;
            if (hdr_bad_in) begin
               rsp_status_in = mrrc_pkg::STATUS_HEADER_BAD;
            end else if (crc_bad) begin
               rsp_status_in = mrrc_pkg::STATUS_CRC_BAD;
            end else begin
               rsp_status_in = mrrc_pkg::STATUS_OK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff   <= 8'd1;
         function_ff  <= 8'd3;
         length_ff    <= 8'd7;
         pos_ff       <= 8'd0;
         crc_ff       <= mrrc_pkg::CRC_SEED;
         hdr_bad_ff   <= 1'b0;
         low_bad_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         hdr_bad_ff   <= hdr_bad_in;
         low_bad_ff   <= low_bad_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               mrrc_pkg::CSR_STATION_ADDRESS: station_ff  <= csr_wdata;
               mrrc_pkg::CSR_FUNCTION_CODE:   function_ff <= csr_wdata;
               mrrc_pkg::CSR_FRAME_LENGTH:    length_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_crc_ff    <= rsp_crc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_crc_ff, rsp_status_ff};

   // a stalled result blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request accepted while result stalled");

   // a new result only follows an accepted request
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_tready)) |-> $past(req_accept))
      else $error("result without request");

   // frame start always leaves position one
   a_start_pos: assert property (@(posedge clock) disable iff (reset)
      (req_accept && start) |=> (pos_ff == 8'd1))
      else $error("frame start did not restart position");

   // status code is always a defined one
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_tdata[1:0] != 2'd3))
      else $error("undefined status code");

endmodule

`default_nettype wire

/* bench/modbus_rtu_response_checker_top_tb.sv */
// Self-checking testbench for the Modbus RTU response checker: byte requests in, verdicts checked.
module modbus_rtu_response_checker_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;

   // damage applied to a built frame
   localparam logic [5:0] DMG_NONE   = 6'b000000;
   localparam logic [5:0] DMG_ADDR   = 6'b000001;
   localparam logic [5:0] DMG_FUNC   = 6'b000010;
   localparam logic [5:0] DMG_COUNT  = 6'b000100;
   localparam logic [5:0] DMG_CRC_LO = 6'b001000;
   localparam logic [5:0] DMG_CRC_HI = 6'b010000;
   localparam logic [5:0] DMG_FLIP   = 6'b100000;

   typedef struct {
      mrrc_pkg::status_type status;
      logic [15:0]          crc;
   } verdict_type;

   class verdict_scoreboard;
      logic [7:0]  station_address;
      logic [7:0]  function_code;
      logic [7:0]  frame_length;
      logic [7:0]  byte_pos;
      logic [15:0] crc_acc;
      bit          header_bad;
      bit          crc_low_bad;
      verdict_type pending_verdicts[$];
      int          mismatches;

      function new();
         station_address = 8'd1;
         function_code   = 8'd3;
         frame_length    = 8'd7;
         byte_pos        = 8'd0;
         crc_acc         = mrrc_pkg::CRC_SEED;
         header_bad      = 1'b0;
         crc_low_bad     = 1'b0;
         mismatches      = 0;
      endfunction

      function logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
         logic [15:0] c;
         c = crc ^ {8'h00, b};
         for (int k = 0; k < 8; k++) begin
            if (c[0]) c = (c >> 1) ^ mrrc_pkg::CRC_POLY;
            else c = c >> 1;
         end
         return c;
      endfunction

      function logic [7:0] active_length();
         return (frame_length < mrrc_pkg::MIN_LEN) ? mrrc_pkg::MIN_LEN : frame_length;
      endfunction

      function void set_register(logic [mrrc_pkg::CSR_IDX_W-1:0] idx, logic [7:0] val);
         case (idx)
            mrrc_pkg::CSR_STATION_ADDRESS: station_address = val;
            mrrc_pkg::CSR_FUNCTION_CODE:   function_code = val;
            mrrc_pkg::CSR_FRAME_LENGTH:    frame_length = val;
            default: ;
         endcase
      endfunction

      // Advances the frame state by one accepted request; queues a verdict on the final byte.
      function void take_byte(logic [7:0] rx, bit start);
         logic [7:0]  len;
         logic [7:0]  pos;
         verdict_type v;
         len = active_length();
         if (start) begin
            byte_pos    = 8'd0;
            crc_acc     = mrrc_pkg::CRC_SEED;
            header_bad  = 1'b0;
            crc_low_bad = 1'b0;
         end else if (byte_pos >= len) begin
            return;
         end
         pos = byte_pos;
         if ((pos == 8'd0 && rx != station_address) ||
             (pos == 8'd1 && rx != function_code) ||
             (pos == 8'd2 && rx != len - mrrc_pkg::MIN_LEN))
            header_bad = 1'b1;
         byte_pos = pos + 8'd1;
         if (pos < len - 8'd2) begin
            crc_acc = crc16_step(crc_acc, rx);
         end else if (pos == len - 8'd2) begin
            crc_low_bad = (rx != crc_acc[7:0]);
         end else begin
            v.crc = crc_acc;
            if (header_bad) v.status = mrrc_pkg::STATUS_HEADER_BAD;
            else if (crc_low_bad || rx != crc_acc[15:8]) v.status = mrrc_pkg::STATUS_CRC_BAD;
            else v.status = mrrc_pkg::STATUS_OK;
            pending_verdicts.push_back(v);
         end
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         mismatches++;
         $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      endtask

      task check_verdict(logic [mrrc_pkg::RSP_DATA_W-1:0] data);
         verdict_type v;
         if (pending_verdicts.size() == 0) begin
            report("unexpected result", data, 0);
            return;
         end
         v = pending_verdicts.pop_front();
         if (data[1:0] !== v.status) report("check_status", data[1:0], v.status);
         if (data[17:2] !== v.crc) report("computed_crc", data[17:2], v.crc);
         if (data[23:18] !== 6'd0) report("padding", data[23:18], 0);
      endtask
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [mrrc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [mrrc_pkg::REQ_USER_W-1:0] req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [mrrc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_we = 1'b0;
   logic [mrrc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [mrrc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   bit                idling_on = 1'b1;
   int                rsp_stall_left = 0;
   int                cycle_count = 0;
   verdict_scoreboard sb;

   modbus_rtu_response_checker_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_verdict(rsp_tdata);
      if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (idling_on && $urandom_range(0, 6) == 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 10);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   task automatic send_request(input logic [7:0] rx, input bit start);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      sb.take_byte(rx, start);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending_verdicts.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input logic [mrrc_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [7:0] val);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_register(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Builds a frame for the current settings, damages it, and sends the first cut bytes
   // (all of them when cut is 0, negative or above the length). fill < 0 gives random payload.
   task automatic send_frame(input logic [5:0] damage, input int cut, input bit lead_start,
                             input int fill);
      logic [7:0]  fb[$];
      logic [15:0] crc;
      int          len;
      int          idx;
      len = sb.active_length();
      fb.push_back(sb.station_address);
      fb.push_back(sb.function_code);
      fb.push_back(8'(len - mrrc_pkg::MIN_LEN));
      while (fb.size() < len - 2) fb.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
      crc = mrrc_pkg::CRC_SEED;
      foreach (fb[i]) crc = sb.crc16_step(crc, fb[i]);
      fb.push_back(crc[7:0]);
      fb.push_back(crc[15:8]);
      if (damage & DMG_ADDR)   fb[0] = fb[0] ^ 8'($urandom_range(1, 255));
      if (damage & DMG_FUNC)   fb[1] = fb[1] ^ 8'($urandom_range(1, 255));
      if (damage & DMG_COUNT)  fb[2] = fb[2] ^ 8'($urandom_range(1, 255));
      if (damage & DMG_CRC_LO) fb[len-2] = fb[len-2] ^ 8'($urandom_range(1, 255));
      if (damage & DMG_CRC_HI) fb[len-1] = fb[len-1] ^ 8'($urandom_range(1, 255));
      if (damage & DMG_FLIP) begin
         idx = $urandom_range(0, len - 1);
         fb[idx] = fb[idx] ^ (8'd1 << $urandom_range(0, 7));
      end
      if (cut <= 0 || cut > len) cut = len;
      for (int i = 0; i < cut; i++) send_request(fb[i], (i == 0) && lead_start);
   endtask

   initial begin
      int         sent;
      int         pick;
      int         len;
      int         n;
      logic [5:0] dmg;

      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // first byte after reset opens a frame even without a start flag
      send_frame(DMG_NONE, 0, 1'b0, 8'hFF);
      send_request(8'h5A, 1'b0);                           // past the end, dropped
      write_register(mrrc_pkg::CSR_FRAME_LENGTH, 8'd3);    // below minimum, acts as five
      send_frame(DMG_ADDR | DMG_CRC_HI, 0, 1'b1, -1);
      send_frame(DMG_NONE, 2, 1'b1, -1);                   // abandoned by the next start
      send_frame(DMG_CRC_HI, 0, 1'b1, 8'h00);
      write_register(mrrc_pkg::CSR_FRAME_LENGTH, 8'd8);
      send_frame(DMG_NONE, 6, 1'b1, -1);
      write_register(mrrc_pkg::CSR_FRAME_LENGTH, 8'd5);    // shrinks below position: frame over
      send_request(8'hC3, 1'b0);

      for (int phase = 0; phase < 8; phase++) begin
         idling_on = (phase != 3) && (phase < 6);
         case (phase)
            0: begin
               write_register(mrrc_pkg::CSR_STATION_ADDRESS, 8'h00);
               write_register(mrrc_pkg::CSR_FUNCTION_CODE, 8'hFF);
               write_register(mrrc_pkg::CSR_FRAME_LENGTH, 8'd5);
            end
            1: begin
               write_register(mrrc_pkg::CSR_STATION_ADDRESS, 8'hFF);
               write_register(mrrc_pkg::CSR_FUNCTION_CODE, 8'h00);
               write_register(mrrc_pkg::CSR_FRAME_LENGTH, 8'd0);
            end
            2: begin
               write_register(mrrc_pkg::CSR_STATION_ADDRESS, 8'($urandom));
               write_register(mrrc_pkg::CSR_FUNCTION_CODE, 8'($urandom));
               write_register(mrrc_pkg::CSR_FRAME_LENGTH, 8'd4);
            end
            4: begin
               write_register(mrrc_pkg::CSR_STATION_ADDRESS, 8'($urandom));
               write_register(mrrc_pkg::CSR_FRAME_LENGTH, 8'd255);
            end
            default: begin
               write_register(mrrc_pkg::CSR_STATION_ADDRESS, 8'($urandom));
               write_register(mrrc_pkg::CSR_FUNCTION_CODE, 8'($urandom));
               write_register(mrrc_pkg::CSR_FRAME_LENGTH, 8'($urandom_range(5, 14)));
            end
         endcase

         if (phase == 4) begin
            send_frame(DMG_NONE, 0, 1'b1, -1);
         end else begin
            sent = 0;
            while (sent < 30) begin
               pick = $urandom_range(0, 19);
               len  = sb.active_length();
               dmg  = ($urandom_range(0, 9) < 6) ? DMG_NONE : 6'($urandom_range(1, 63));
               if (pick < 13) begin
                  send_frame(dmg, 0, 1'b1, -1);
                  sent += len;
               end else if (pick < 16) begin
                  n = $urandom_range(1, len - 1);
                  send_frame(dmg, n, 1'b1, -1);
                  sent += n;
               end else if (pick < 18) begin
                  n = $urandom_range(1, 6);
                  repeat (n) send_request(8'($urandom), 1'($urandom_range(0, 1)));
                  sent += n;
               end else begin
                  send_frame(dmg, 0, 1'b1, -1);
                  repeat ($urandom_range(1, 3)) send_request(8'($urandom), 1'b0);
                  sent += len;
               end
            end
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (sb.pending_verdicts.size() != 0)
         sb.report("results never arrived", 0, sb.pending_verdicts.size());
      if (sb.mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
